>>> rtl/best_fit_block_allocator_assert.svh
// Assertion macros for the best-fit block allocator.
// Used by rtl/best_fit_block_allocator.sv; needs nothing else.
`ifndef BEST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define BEST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS

// Check that a property holds at every clock edge outside reset.
`define BFBA_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("bfba assertion failed");

// Check that a condition never holds at any clock edge outside reset.
`define BFBA_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("bfba forbidden condition seen");

`else

`define BFBA_ASSERT(label, clk, rst, prop)

`define BFBA_NEVER(label, clk, rst, cond)

`endif

`endif

>>> rtl/bfba_pkg.sv
// Shared types and constants of the best-fit block allocator.
// Used by rtl/best_fit_block_allocator.sv; depends on nothing.
package bfba_pkg;

  localparam int unsigned HEAP_BYTES = 1048576;
  localparam int unsigned PAGE_BYTES = 4096;
  localparam int unsigned HDR_BYTES  = 16;

  localparam int unsigned ADDR_W = 20;
  localparam int unsigned SIZE_W = 21;
  localparam int unsigned REQ_W  = 32;

  localparam logic [1:0] FUNC_ALLOC   = 2'd0;
  localparam logic [1:0] FUNC_FREE    = 2'd1;
  localparam logic [1:0] FUNC_RELEASE = 2'd2;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_SIZE   = 3'd1;
  localparam logic [2:0] ST_NO_MEM     = 3'd2;
  localparam logic [2:0] ST_NULL       = 3'd3;
  localparam logic [2:0] ST_FREE_AGAIN = 3'd4;
  localparam logic [2:0] ST_NOT_BLOCK  = 3'd5;

  typedef struct packed {
    logic              used;
    logic [SIZE_W-1:0] size;
    logic [SIZE_W-1:0] start;
  } entry_t;

endpackage

>>> rtl/bfba_ram.sv
// Generic single-port RAM with registered read.
// Used by rtl/best_fit_block_allocator.sv; depends on nothing.
module bfba_ram #(
  parameter int WIDTH = 43,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                       wdata,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> rtl/best_fit_block_allocator.sv
// Best-fit block allocator: top level with block table scan sequencer.
// Depends on bfba_pkg, bfba_ram and best_fit_block_allocator_assert.svh.
//
//   channel   handshake             payload
//   request   req_valid/req_stall   func, request_bytes, block_address
//   result    res_valid/res_stall   status, payload_address
//
// Allocate and free walk the block table one entry per cycle on the RAM read
// port, then pass through the decide and done states; the done state loads the
// result register, and no new request is taken until the sequencer is idle again.
// Release-all, unused codes, bad sizes and null frees go straight to the done state.
// Reset (rst, synchronous) empties the heap; only entries below block_count are read.
// While res_stall holds a result, one more request is taken and its result held.
`include "best_fit_block_allocator_assert.svh"

module best_fit_block_allocator
  import bfba_pkg::*;
#(
  parameter int MAX_BLOCKS = 256
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  output logic                     req_stall,
  input  logic [1:0]               func,
  input  logic signed [REQ_W-1:0]  request_bytes,
  input  logic [ADDR_W-1:0]        block_address,
  output logic                     res_valid,
  input  logic                     res_stall,
  output logic [2:0]               status,
  output logic [ADDR_W-1:0]        payload_address
);

  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int ENT_W = 1 + 2 * SIZE_W;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;
  localparam logic [1:0] S_DONE   = 2'd3;

  // Control state
  logic [1:0]        state, state_next;
  logic [CNT_W-1:0]  block_count, block_count_next;
  logic [SIZE_W-1:0] heap_top, heap_top_next;
  logic [CNT_W-1:0]  issue_idx, issue_idx_next;
  logic              rd_pend, rd_pend_next;
  logic              hit, hit_next;
  logic              res_valid_next;

  // Working data of the current request
  logic              op_free, op_free_next;
  logic [REQ_W-2:0]  req_q, req_q_next;
  logic [ADDR_W-1:0] addr_q, addr_q_next;
  logic [IDX_W-1:0]  rd_idx, rd_idx_next;
  logic [IDX_W-1:0]  hit_idx, hit_idx_next;
  logic              hit_used, hit_used_next;
  logic [SIZE_W-1:0] hit_size, hit_size_next;
  logic [SIZE_W-1:0] hit_start, hit_start_next;
  logic [2:0]        rs_status, rs_status_next;
  logic [ADDR_W-1:0] rs_addr, rs_addr_next;
  logic [2:0]        status_next;
  logic [ADDR_W-1:0] payload_address_next;

  // Table RAM port
  logic              ram_we;
  logic [IDX_W-1:0]  ram_addr;
  entry_t            ram_wdata;
  logic [ENT_W-1:0]  ram_rdata;
  entry_t            rd_ent;

  // Datapath terms
  logic              accept;
  logic [REQ_W-1:0]  need;
  logic [REQ_W:0]    round_sum;
  logic [REQ_W:0]    rounded;
  logic [REQ_W:0]    end_sum;
  logic              fits_heap;
  logic [SIZE_W-1:0] rd_payload;

  assign accept    = req_valid && !req_stall;
  assign req_stall = (state != S_IDLE);
  assign rd_ent    = entry_t'(ram_rdata);

  // Best-fit threshold: request plus header
  assign need = {1'b0, req_q} + REQ_W'(HDR_BYTES);

  // Round the request up to whole pages and place the new block at the top
  assign round_sum  = {2'b00, req_q} + (REQ_W + 1)'(PAGE_BYTES - 1);
  assign rounded    = round_sum & ~((REQ_W + 1)'(PAGE_BYTES - 1));
  assign end_sum    = (REQ_W + 1)'(heap_top) + rounded + (REQ_W + 1)'(HDR_BYTES);
  assign fits_heap  = (end_sum <= (REQ_W + 1)'(HEAP_BYTES));
  assign rd_payload = rd_ent.start + SIZE_W'(HDR_BYTES);

  bfba_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next           = state;
    block_count_next     = block_count;
    heap_top_next        = heap_top;
    issue_idx_next       = issue_idx;
    rd_pend_next         = 1'b0;
    hit_next             = hit;
    res_valid_next       = res_valid;
    op_free_next         = op_free;
    req_q_next           = req_q;
    addr_q_next          = addr_q;
    rd_idx_next          = rd_idx;
    hit_idx_next         = hit_idx;
    hit_used_next        = hit_used;
    hit_size_next        = hit_size;
    hit_start_next       = hit_start;
    rs_status_next       = rs_status;
    rs_addr_next         = rs_addr;
    status_next          = status;
    payload_address_next = payload_address;
    ram_we               = 1'b0;
    ram_addr             = issue_idx[IDX_W-1:0];
    ram_wdata            = '0;

    // Drop the result once the receiver takes it
    if (res_valid && !res_stall) begin
      res_valid_next = 1'b0;
    end

    case (state)
      S_IDLE: begin
        if (accept) begin
          op_free_next   = (func == FUNC_FREE);
          req_q_next     = request_bytes[REQ_W-2:0];
          addr_q_next    = block_address;
          issue_idx_next = '0;
          hit_next       = 1'b0;
          rs_addr_next   = '0;
          rs_status_next = ST_OK;
          state_next     = S_DONE;
          case (func)
            FUNC_ALLOC: begin
              if (request_bytes[REQ_W-1] || request_bytes == '0) begin
                rs_status_next = ST_BAD_SIZE;
              end else begin
                state_next = S_SCAN;
              end
            end
            FUNC_FREE: begin
              if (block_address == '0) begin
                rs_status_next = ST_NULL;
              end else begin
                state_next = S_SCAN;
              end
            end
            FUNC_RELEASE: begin
              block_count_next = '0;
              heap_top_next    = '0;
            end
            default: begin
              rs_status_next = ST_OK;
            end
          endcase
        end
      end

      S_SCAN: begin
        // Issue the next table read; the data returns in the next cycle
        if (issue_idx < block_count) begin
          issue_idx_next = issue_idx + CNT_W'(1);
          rd_pend_next   = 1'b1;
          rd_idx_next    = issue_idx[IDX_W-1:0];
        end else begin
          state_next = S_DECIDE;
        end
        if (rd_pend) begin
          if (op_free) begin
            // First block whose payload offset matches wins
            if (!hit && rd_payload == {1'b0, addr_q}) begin
              hit_next       = 1'b1;
              hit_idx_next   = rd_idx;
              hit_used_next  = rd_ent.used;
              hit_size_next  = rd_ent.size;
              hit_start_next = rd_ent.start;
            end
          end else begin
            // Smallest free block that fits; strict compare keeps the earliest
            if (!rd_ent.used && REQ_W'(rd_ent.size) >= need &&
                (!hit || rd_ent.size < hit_size)) begin
              hit_next       = 1'b1;
              hit_idx_next   = rd_idx;
              hit_used_next  = rd_ent.used;
              hit_size_next  = rd_ent.size;
              hit_start_next = rd_ent.start;
            end
          end
        end
      end

      S_DECIDE: begin
        state_next   = S_DONE;
        rs_addr_next = '0;
        if (op_free) begin
          if (!hit) begin
            rs_status_next = ST_NOT_BLOCK;
          end else if (!hit_used) begin
            rs_status_next = ST_FREE_AGAIN;
          end else begin
            ram_we         = 1'b1;
            ram_addr       = hit_idx;
            ram_wdata      = '{used: 1'b0, size: hit_size, start: hit_start};
            rs_status_next = ST_OK;
          end
        end else if (hit) begin
          ram_we         = 1'b1;
          ram_addr       = hit_idx;
          ram_wdata      = '{used: 1'b1, size: hit_size, start: hit_start};
          rs_status_next = ST_OK;
          rs_addr_next   = ADDR_W'(hit_start + SIZE_W'(HDR_BYTES));
        end else if (block_count == CNT_W'(MAX_BLOCKS) || !fits_heap) begin
          rs_status_next = ST_NO_MEM;
        end else begin
          // Append a new block at the heap top
          ram_we           = 1'b1;
          ram_addr         = block_count[IDX_W-1:0];
          ram_wdata        = '{used: 1'b1, size: req_q[SIZE_W-1:0], start: heap_top};
          block_count_next = block_count + CNT_W'(1);
          heap_top_next    = end_sum[SIZE_W-1:0];
          rs_status_next   = ST_OK;
          rs_addr_next     = ADDR_W'(heap_top + SIZE_W'(HDR_BYTES));
        end
      end

      S_DONE: begin
        // Hold the result until the output register is free
        if (!res_valid || !res_stall) begin
          res_valid_next       = 1'b1;
          status_next          = rs_status;
          payload_address_next = rs_addr;
          state_next           = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      block_count <= '0;
      heap_top    <= '0;
      issue_idx   <= '0;
      rd_pend     <= 1'b0;
      hit         <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      block_count <= block_count_next;
      heap_top    <= heap_top_next;
      issue_idx   <= issue_idx_next;
      rd_pend     <= rd_pend_next;
      hit         <= hit_next;
      res_valid   <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op_free         <= op_free_next;
    req_q           <= req_q_next;
    addr_q          <= addr_q_next;
    rd_idx          <= rd_idx_next;
    hit_idx         <= hit_idx_next;
    hit_used        <= hit_used_next;
    hit_size        <= hit_size_next;
    hit_start       <= hit_start_next;
    rs_status       <= rs_status_next;
    rs_addr         <= rs_addr_next;
    status          <= status_next;
    payload_address <= payload_address_next;
  end

  `BFBA_ASSERT(a_count_bound, clk, rst, block_count <= CNT_W'(MAX_BLOCKS))
  `BFBA_ASSERT(a_heap_bound, clk, rst, heap_top <= SIZE_W'(HEAP_BYTES))
  `BFBA_ASSERT(a_status_code, clk, rst, res_valid |-> status <= ST_NOT_BLOCK)
  `BFBA_ASSERT(a_write_decide, clk, rst, ram_we |-> state == S_DECIDE)
  `BFBA_NEVER(a_read_in_scan, clk, rst, rd_pend && state != S_SCAN)

endmodule
